// ===== rtl/bridge_adc_serial_reader_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef BRIDGE_ADC_SERIAL_READER_MACROS_SVH
`define BRIDGE_ADC_SERIAL_READER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BSR_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bsr assertion failed");

// Next-cycle implication, disabled while in reset.
`define BSR_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bsr assertion failed");

`endif

// ===== rtl/bsr_pkg.sv =====
package bsr_pkg;

    localparam int unsigned DATA_BITS = 24;
    localparam logic [23:0] SIGN_FLIP = 24'h80_0000;

    typedef logic [3:0] step_t;

    // Microprogram addresses
    localparam step_t ST_IDLE     = 4'd0;
    localparam step_t ST_DHIGH    = 4'd1;
    localparam step_t ST_DLOW     = 4'd2;
    localparam step_t ST_GHIGH    = 4'd3;
    localparam step_t ST_GLOW     = 4'd4;
    localparam step_t ST_SAMPLE   = 4'd5;
    localparam step_t ST_DIV_LOAD = 4'd6;
    localparam step_t ST_DIV_STEP = 4'd7;
    localparam step_t ST_AVG      = 4'd8;

    // Register indexes on the configuration port
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_GAIN  = 3'd0;
    localparam reg_idx_t REG_AVG   = 3'd1;
    localparam reg_idx_t REG_TARE  = 3'd2;
    localparam reg_idx_t REG_HALF  = 3'd3;
    localparam reg_idx_t REG_PDOWN = 3'd4;

    typedef enum logic [1:0] {
        W_NONE      = 2'd0,
        W_DIN_LOW   = 2'd1,
        W_PHASE_END = 2'd2
    } wait_t;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_START    = 4'd1,
        OP_SHIFT    = 4'd2,
        OP_GAIN     = 4'd3,
        OP_ACCUM    = 4'd4,
        OP_DIV_LOAD = 4'd5,
        OP_DIV_STEP = 4'd6,
        OP_AVG      = 4'd7,
        OP_PD       = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        B_ALWAYS    = 3'd0,
        B_LAST_BIT  = 3'd1,
        B_LAST_GAIN = 3'd2,
        B_AVG_DUE   = 3'd3,
        B_DIV_LAST  = 3'd4
    } br_t;

    typedef enum logic [1:0] {
        EM_NONE     = 2'd0,
        EM_ALWAYS   = 2'd1,
        EM_ON_FALSE = 2'd2
    } emit_t;

    typedef struct packed {
        logic  take;
        logic  clk;
        wait_t wt;
        op_t   op;
        br_t   br;
        emit_t emit;
        step_t jt;
        step_t jf;
    } ucode_t;

    typedef struct packed {
        logic din_low;
        logic phase_end;
        logic last_bit;
        logic last_gain;
        logic avg_due;
        logic div_last;
    } status_t;

    typedef struct packed {
        op_t  op;
        logic op_en;
        logic tick_en;
        logic emit;
        logic clk;
    } ctl_t;

    typedef struct packed {
        logic        sample_valid;
        logic [23:0] raw_sample;
        logic        average_valid;
        logic [23:0] average_raw;
        logic [25:0] net_value;
    } res_t;

    function automatic logic [4:0] gain_pulses(input logic [1:0] g);
        logic [4:0] n;
        unique case (g)
            2'd1:    n = 5'd3;
            2'd2:    n = 5'd2;
            default: n = 5'd1;
        endcase
        return n;
    endfunction

    // Control store: take, clk, wait, op, branch, emit, true target, false target
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        unique case (s)
            ST_IDLE:     w = '{1'b1, 1'b0, W_DIN_LOW, OP_START, B_ALWAYS, EM_ALWAYS,
                               ST_DHIGH, ST_DHIGH};
            ST_DHIGH:    w = '{1'b1, 1'b1, W_PHASE_END, OP_NONE, B_ALWAYS, EM_ALWAYS,
                               ST_DLOW, ST_DLOW};
            ST_DLOW:     w = '{1'b1, 1'b0, W_PHASE_END, OP_SHIFT, B_LAST_BIT, EM_ALWAYS,
                               ST_GHIGH, ST_DHIGH};
            ST_GHIGH:    w = '{1'b1, 1'b1, W_PHASE_END, OP_NONE, B_ALWAYS, EM_ALWAYS,
                               ST_GLOW, ST_GLOW};
            ST_GLOW:     w = '{1'b1, 1'b0, W_PHASE_END, OP_GAIN, B_LAST_GAIN, EM_ON_FALSE,
                               ST_SAMPLE, ST_GHIGH};
            ST_SAMPLE:   w = '{1'b0, 1'b0, W_NONE, OP_ACCUM, B_AVG_DUE, EM_ON_FALSE,
                               ST_DIV_LOAD, ST_IDLE};
            ST_DIV_LOAD: w = '{1'b0, 1'b0, W_NONE, OP_DIV_LOAD, B_ALWAYS, EM_NONE,
                               ST_DIV_STEP, ST_DIV_STEP};
            ST_DIV_STEP: w = '{1'b0, 1'b0, W_NONE, OP_DIV_STEP, B_DIV_LAST, EM_NONE,
                               ST_AVG, ST_DIV_STEP};
            ST_AVG:      w = '{1'b0, 1'b0, W_NONE, OP_AVG, B_ALWAYS, EM_ALWAYS,
                               ST_IDLE, ST_IDLE};
            default:     w = '{1'b0, 1'b0, W_NONE, OP_NONE, B_ALWAYS, EM_NONE,
                               ST_IDLE, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/bsr_seq.sv =====
module bsr_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             item_valid,
    input  logic             slot_free,
    input  logic             power_down,
    input  bsr_pkg::status_t st,
    output logic             item_ready,
    output bsr_pkg::ctl_t    ctl
);

    bsr_pkg::step_t  step_reg, step_next;
    bsr_pkg::ucode_t word;
    logic            go, pd_hit, met, brc;

    assign word       = bsr_pkg::ucode_rom(step_reg);
    assign item_ready = word.take && slot_free;
    // item steps wait for an item and room at the output; internal steps only for room
    assign go         = slot_free && (!word.take || item_valid);
    assign pd_hit     = word.take && power_down;

    always_comb begin
        unique case (word.wt)
            bsr_pkg::W_NONE:      met = 1'b1;
            bsr_pkg::W_DIN_LOW:   met = st.din_low;
            bsr_pkg::W_PHASE_END: met = st.phase_end;
            default:              met = 1'b0;
        endcase
    end

    always_comb begin
        unique case (word.br)
            bsr_pkg::B_ALWAYS:    brc = 1'b1;
            bsr_pkg::B_LAST_BIT:  brc = st.last_bit;
            bsr_pkg::B_LAST_GAIN: brc = st.last_gain;
            bsr_pkg::B_AVG_DUE:   brc = st.avg_due;
            bsr_pkg::B_DIV_LAST:  brc = st.div_last;
            default:              brc = 1'b0;
        endcase
    end

    always_comb begin
        ctl.op      = pd_hit ? bsr_pkg::OP_PD : word.op;
        ctl.op_en   = go && (pd_hit || met);
        ctl.tick_en = go && !pd_hit && (word.wt == bsr_pkg::W_PHASE_END);
        ctl.clk     = pd_hit || word.clk;
        ctl.emit    = go && (pd_hit || (word.emit == bsr_pkg::EM_ALWAYS)
                      || ((word.emit == bsr_pkg::EM_ON_FALSE) && !(met && brc)));
    end

    always_comb begin
        step_next = step_reg;
        if (go) begin
            priority if (pd_hit) begin
                step_next = bsr_pkg::ST_IDLE;
            end else if (!met) begin
                step_next = step_reg;
            end else begin
                step_next = brc ? word.jt : word.jf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= bsr_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/bsr_div.sv =====
module bsr_div (
    input  logic          aclk,
    input  logic          aresetn,
    input  bsr_pkg::ctl_t ctl,
    input  logic [31:0]   dividend,
    input  logic [7:0]    divisor,
    output logic [23:0]   quotient,
    output logic          div_last
);

    logic [31:0] quo_reg;
    logic [7:0]  rem_reg;
    logic [4:0]  cnt_reg;
    logic [8:0]  trial;
    logic [8:0]  diff;
    logic        fits;

    // restoring division, one quotient bit per step
    assign trial    = {rem_reg, quo_reg[31]};
    assign fits     = trial >= {1'b0, divisor};
    assign diff     = trial - {1'b0, divisor};
    assign div_last = cnt_reg == 5'd31;
    // mean of 24-bit samples always fits in 24 bits
    assign quotient = quo_reg[23:0];

    always_ff @(posedge aclk) begin
        if (ctl.op_en && ctl.op == bsr_pkg::OP_DIV_LOAD) begin
            quo_reg <= dividend;
            rem_reg <= 8'd0;
        end else if (ctl.op_en && ctl.op == bsr_pkg::OP_DIV_STEP) begin
            quo_reg <= {quo_reg[30:0], fits};
            rem_reg <= fits ? diff[7:0] : trial[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 5'd0;
        end else if (ctl.op_en && ctl.op == bsr_pkg::OP_DIV_LOAD) begin
            cnt_reg <= 5'd0;
        end else if (ctl.op_en && ctl.op == bsr_pkg::OP_DIV_STEP) begin
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

endmodule

// ===== rtl/bsr_dp.sv =====
module bsr_dp (
    input  logic             aclk,
    input  logic             aresetn,
    input  bsr_pkg::ctl_t    ctl,
    input  logic             din,
    input  logic             div_last,
    input  logic [23:0]      quotient,
    input  logic [1:0]       gain_select,
    input  logic [7:0]       average_count,
    input  logic [24:0]      tare_offset,
    input  logic [7:0]       half_period,
    output bsr_pkg::status_t st,
    output logic [31:0]      sum,
    output logic [7:0]       samples,
    output bsr_pkg::res_t    res
);

    logic [7:0]  tick_reg;
    logic [4:0]  pulse_reg;
    logic [23:0] shift_reg;
    logic [31:0] sum_reg;
    logic [7:0]  samples_reg;

    logic [7:0]  eff_half, need;
    logic [8:0]  tick_inc;
    logic [4:0]  pulse_inc;
    logic [7:0]  samples_inc;
    logic [23:0] sample_word;
    logic        do_op;

    assign eff_half    = (half_period == 8'd0) ? 8'd1 : half_period;
    assign need        = (average_count == 8'd0) ? 8'd1 : average_count;
    assign tick_inc    = {1'b0, tick_reg} + 9'd1;
    assign pulse_inc   = pulse_reg + 5'd1;
    assign samples_inc = samples_reg + 8'd1;
    assign sample_word = shift_reg ^ bsr_pkg::SIGN_FLIP;
    assign do_op       = ctl.op_en;

    always_comb begin
        st.din_low   = !din;
        st.phase_end = tick_inc >= {1'b0, eff_half};
        st.last_bit  = pulse_inc >= 5'(bsr_pkg::DATA_BITS);
        st.last_gain = pulse_inc >= bsr_pkg::gain_pulses(gain_select);
        st.avg_due   = samples_inc >= need;
        st.div_last  = div_last;
    end

    assign sum     = sum_reg;
    assign samples = samples_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg    <= 8'd0;
            pulse_reg   <= 5'd0;
            sum_reg     <= 32'd0;
            samples_reg <= 8'd0;
        end else begin
            if (ctl.tick_en) begin
                tick_reg <= st.phase_end ? 8'd0 : tick_inc[7:0];
            end
            if (do_op) begin
                unique case (ctl.op)
                    bsr_pkg::OP_START, bsr_pkg::OP_PD: begin
                        tick_reg  <= 8'd0;
                        pulse_reg <= 5'd0;
                    end
                    bsr_pkg::OP_SHIFT: begin
                        pulse_reg <= st.last_bit ? 5'd0 : pulse_inc;
                    end
                    bsr_pkg::OP_GAIN: begin
                        pulse_reg <= st.last_gain ? 5'd0 : pulse_inc;
                    end
                    bsr_pkg::OP_ACCUM: begin
                        sum_reg     <= sum_reg + {8'd0, sample_word};
                        samples_reg <= samples_inc;
                    end
                    bsr_pkg::OP_AVG: begin
                        sum_reg     <= 32'd0;
                        samples_reg <= 8'd0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_op && ctl.op == bsr_pkg::OP_START) begin
            shift_reg <= 24'd0;
        end else if (do_op && ctl.op == bsr_pkg::OP_SHIFT) begin
            shift_reg <= {shift_reg[22:0], din};
        end
    end

    always_comb begin
        res.sample_valid  = do_op && (ctl.op == bsr_pkg::OP_ACCUM || ctl.op == bsr_pkg::OP_AVG);
        res.average_valid = do_op && (ctl.op == bsr_pkg::OP_AVG);
        res.raw_sample    = res.sample_valid ? sample_word : 24'd0;
        res.average_raw   = res.average_valid ? quotient : 24'd0;
        res.net_value     = res.average_valid
                            ? ({2'b00, quotient} - {tare_offset[24], tare_offset}) : 26'd0;
    end

endmodule

// ===== rtl/bridge_adc_serial_reader.sv =====
// Serial reader for a 24-bit bridge converter with a clock/data pin pair.
// Each s_ item is one tick carrying the sampled data-out level (s_tdata[0]);
// each tick yields exactly one m_ item with the clock level to drive, plus a
// raw sample and/or an averaged result on the tick where they finish.
// Registers sit on the APB-style port: gain select, average count, tare offset,
// half period, power down; the user must write these only while the block is idle.
// The block does not enforce this. Each tick's item, but the final gain
// tick's, is registered on m_ as the tick is accepted, and a tick is taken
// every cycle while the output is free. The final gain tick is followed by
// internal steps that produce its item: sample accumulate, and when an average
// is due, divider load, 32 restoring steps and result, all with s_tready low.
// Reset returns the sequencer to idle, clears the counters, the running sum
// and the registers to their defaults (average count and half period 1).
// If m_tready is low the output register holds its item and s_tready drops;
// no tick is taken until the item has gone. Power down drives the clock high
// and drops any transfer in progress, keeping the running sum.
`include "bridge_adc_serial_reader_macros.svh"

module bridge_adc_serial_reader (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] data_line, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] clock_line, [24:1] raw_sample, [48:25] average_raw, [74:49] net_value
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,   // [0] sample_valid, [1] average_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  gain_reg;
    logic [7:0]  avg_cnt_reg;
    logic [24:0] tare_reg;
    logic [7:0]  half_reg;
    logic        pd_reg;

    logic              m_valid_reg;
    logic [79:0]       m_data_reg;
    logic [1:0]        m_user_reg;
    logic              slot_free;
    logic              cfg_wr;
    bsr_pkg::ctl_t     ctl;
    bsr_pkg::status_t  st;
    bsr_pkg::res_t     res;
    logic [31:0]       sum;
    logic [7:0]        samples;
    logic [23:0]       quotient;
    logic              div_last;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= 2'd0;
            avg_cnt_reg <= 8'd1;
            tare_reg    <= 25'd0;
            half_reg    <= 8'd1;
            pd_reg      <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                bsr_pkg::REG_GAIN:  gain_reg    <= pwdata[1:0];
                bsr_pkg::REG_AVG:   avg_cnt_reg <= pwdata[7:0];
                bsr_pkg::REG_TARE:  tare_reg    <= pwdata[24:0];
                bsr_pkg::REG_HALF:  half_reg    <= pwdata[7:0];
                bsr_pkg::REG_PDOWN: pd_reg      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            bsr_pkg::REG_GAIN:  prdata = {30'd0, gain_reg};
            bsr_pkg::REG_AVG:   prdata = {24'd0, avg_cnt_reg};
            bsr_pkg::REG_TARE:  prdata = {7'd0, tare_reg};
            bsr_pkg::REG_HALF:  prdata = {24'd0, half_reg};
            bsr_pkg::REG_PDOWN: prdata = {31'd0, pd_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign slot_free = !m_valid_reg || m_tready;

    bsr_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (s_tvalid),
        .slot_free  (slot_free),
        .power_down (pd_reg),
        .st         (st),
        .item_ready (s_tready),
        .ctl        (ctl)
    );

    bsr_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .din           (s_tdata[0]),
        .div_last      (div_last),
        .quotient      (quotient),
        .gain_select   (gain_reg),
        .average_count (avg_cnt_reg),
        .tare_offset   (tare_reg),
        .half_period   (half_reg),
        .st            (st),
        .sum           (sum),
        .samples       (samples),
        .res           (res)
    );

    bsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .dividend (sum),
        .divisor  (samples),
        .quotient (quotient),
        .div_last (div_last)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            m_data_reg <= {5'd0, res.net_value, res.average_raw, res.raw_sample, ctl.clk};
            m_user_reg <= {res.average_valid, res.sample_valid};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // a tick is only taken when its result has somewhere to go
    `BSR_ASSERT_NOW(a_ready_needs_room, aclk, aresetn, s_tready, (!m_tvalid || m_tready))
    // power down drives the clock high on the very next result
    `BSR_ASSERT_NEXT(a_pd_clock_high, aclk, aresetn, (s_tvalid && s_tready && pd_reg),
                     (m_tvalid && m_tdata[0]))
    `BSR_ASSERT_NOW(a_avg_with_sample, aclk, aresetn, (m_tvalid && m_tuser[1]), m_tuser[0])
    `BSR_ASSERT_NOW(a_sample_clock_low, aclk, aresetn, (m_tvalid && m_tuser[0]), !m_tdata[0])
    `BSR_ASSERT_NOW(a_no_tick_in_div, aclk, aresetn,
                    (ctl.op_en && ctl.op == bsr_pkg::OP_DIV_STEP), !s_tready)

endmodule
